// ----- hw/rtl/nprc_pkg.sv -----
package nprc_pkg;

	// result kinds, same coding as the raw pixel kind
	localparam logic [2:0] CLS_VALID      = 3'd0;
	localparam logic [2:0] CLS_NULL       = 3'd1;
	localparam logic [2:0] CLS_HIGH_REPR  = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_SAT_THRESH = 3'd0;
	localparam logic [2:0] REG_GAIN       = 3'd1;
	localparam logic [2:0] REG_OFS_MODE   = 3'd2;
	localparam logic [2:0] REG_EXPOSURE   = 3'd3;
	localparam logic [2:0] REG_ABS_SCALE  = 3'd4;
	localparam logic [2:0] REG_BACKGROUND = 3'd5;

	// per-pixel data that rides along the chain
	typedef struct packed {
		logic [2:0]         cls;
		logic               calc;
		logic               ov;
		logic signed [31:0] bias;
		logic signed [31:0] dark;
		logic signed [31:0] flat;
		logic signed [31:0] oflat;
		logic signed [31:0] addv;
	} side_t;

	// clamp to signed 32 bits, overflow flag in the top bit
	function automatic logic [32:0] sat36(input logic signed [35:0] v);
		logic [32:0] r;
		if (v > 36'sh0_7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -36'sh0_8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/nprc_div.sv -----
module nprc_div import nprc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] a,
	input  logic signed [32:0] b,
	input  logic [SW-1:0]      in_side,
	output logic               out_valid,
	output logic signed [31:0] q,
	output logic               q_ov,
	output logic [SW-1:0]      out_side
);

	localparam int NW = 32 + FRAC_BITS;

	logic          v_a    [NW+1];
	logic [31:0]   rem_a  [NW+1];
	logic [NW-1:0] nq_a   [NW+1];
	logic [31:0]   dmag_a [NW+1];
	logic          neg_a  [NW+1];
	logic          zero_a [NW+1];
	logic          apos_a [NW+1];
	logic [SW-1:0] side_a [NW+1];

	logic [31:0] amag, bmag;

	// operand magnitudes
	always_comb begin
		amag = a[31] ? 32'(-a) : 32'(a);
		bmag = b[32] ? 32'(-b) : 32'(b);
	end

	// entry stage: signs and magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a[0] <= 1'b0;
		end else if (en) begin
			v_a[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_a[0]  <= '0;
			nq_a[0]   <= {amag, {FRAC_BITS{1'b0}}};
			dmag_a[0] <= bmag;
			neg_a[0]  <= a[31] ^ b[32];
			zero_a[0] <= (b == '0);
			apos_a[0] <= !a[31];
			side_a[0] <= in_side;
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [32:0] sh;
		logic [33:0] diff;
		assign sh   = {rem_a[k], nq_a[k][NW-1]};
		assign diff = {1'b0, sh} - {2'b0, dmag_a[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_a[k+1] <= 1'b0;
			end else if (en) begin
				v_a[k+1] <= v_a[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a[k+1]  <= diff[33] ? sh[31:0] : diff[31:0];
				nq_a[k+1]   <= {nq_a[k][NW-2:0], ~diff[33]};
				dmag_a[k+1] <= dmag_a[k];
				neg_a[k+1]  <= neg_a[k];
				zero_a[k+1] <= zero_a[k];
				apos_a[k+1] <= apos_a[k];
				side_a[k+1] <= side_a[k];
			end
		end
	end

	logic [NW-1:0] mag;
	logic          big_pos, big_neg;
	logic [31:0]   qn;
	logic          ovn;

	// sign, saturation and zero divisor
	always_comb begin
		mag     = nq_a[NW];
		big_pos = |mag[NW-1:31];
		big_neg = (|mag[NW-1:32]) || (mag[31] && (|mag[30:0]));
		if (zero_a[NW]) begin
			ovn = 1'b1;
			qn  = apos_a[NW] ? 32'h7FFF_FFFF : 32'h8000_0000;
		end else if (neg_a[NW]) begin
			ovn = big_neg;
			qn  = big_neg ? 32'h8000_0000 : 32'(-mag[31:0]);
		end else begin
			ovn = big_pos;
			qn  = big_pos ? 32'h7FFF_FFFF : mag[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_a[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q        <= qn;
			q_ov     <= ovn;
			out_side <= side_a[NW];
		end
	end

endmodule

// ----- hw/rtl/nprc_mul.sv -----
module nprc_mul import nprc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  side_t              in_side,
	output logic               out_valid,
	output logic signed [31:0] p,
	output logic               p_ov,
	output side_t              out_side
);

	logic               v_s1;
	logic signed [63:0] prod_s1;
	side_t              side_s1;
	logic [63:0]        m;
	logic [63:0]        r;
	logic               big_pos, big_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// magnitude shift truncates toward zero
	always_comb begin
		m       = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
		r       = m >> FRAC_BITS;
		big_pos = |r[63:31];
		big_neg = (|r[63:32]) || (r[31] && (|r[30:0]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= a * b;
			side_s1  <= in_side;
			out_side <= side_s1;
			if (prod_s1[63]) begin
				p    <= big_neg ? 32'h8000_0000 : 32'(-r[31:0]);
				p_ov <= big_neg;
			end else begin
				p    <= big_pos ? 32'h7FFF_FFFF : r[31:0];
				p_ov <= big_pos;
			end
		end
	end

endmodule

// ----- hw/rtl/nir_pixel_radiometric_calibration_core.sv -----
// channel   | direction | transaction
// s_axis    | in        | tdata: raw, flat, orbit flat, additive, dark, bias; tuser: flags
// m_axis    | out       | tdata: calibrated value; tuser: kind, overflow
// cfg       | in        | register index and write data
//
// one pixel per cycle while the output register is empty or taken; most of the depth
// lies in the four bit-per-stage divider pipelines
// arst_n clears valid bits and restores register defaults
// the whole pipeline advances when the output register is empty or taken
module nir_pixel_radiometric_calibration_core import nprc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// raw_value, flat_value, orbit_flat_value, additive_value, dark_value, bias_value
	input  logic [167:0] s_axis_tdata,
	// raw_class, bad_pixel, plane_special_mask
	input  logic [9:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_value
	output logic [31:0]  m_axis_tdata,
	// out_class, overflow
	output logic [3:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam longint SCL    = 64'sd1 <<< FRAC_BITS;
	localparam longint DOFS_L = (64'sd830690 * SCL + 64'sd50000) / 64'sd100000;
	localparam longint GB_L   = (64'sd215547 * SCL + 64'sd50000) / 64'sd100000;
	localparam longint GD_L   = (64'sd730 * SCL + 64'sd500) / 64'sd1000;
	localparam longint VM_L   = (64'sd954194 * SCL + 64'sd500000) / 64'sd1000000;
	localparam logic signed [35:0] DOFS_C = 36'(DOFS_L);
	localparam logic signed [35:0] GB_C   = 36'(GB_L);
	localparam logic signed [35:0] GD_C   = 36'(GD_L);
	localparam logic signed [35:0] VM_C   = 36'(VM_L);
	localparam int SW = $bits(side_t);

	logic               en;
	logic [7:0]         sat_thresh_q;
	logic [30:0]        gain_q;
	logic [1:0]         ofs_mode_q;
	logic [30:0]        exposure_q;
	logic signed [31:0] abs_scale_q;
	logic signed [31:0] background_q;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_thresh_q <= 8'd255;
			gain_q       <= 31'd65536;
			ofs_mode_q   <= 2'd0;
			exposure_q   <= 31'd65536;
			abs_scale_q  <= 32'sd65536;
			background_q <= 32'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAT_THRESH: sat_thresh_q <= cfg_data[7:0];
				REG_GAIN:       gain_q       <= cfg_data[30:0];
				REG_OFS_MODE:   ofs_mode_q   <= cfg_data[1:0];
				REG_EXPOSURE:   exposure_q   <= cfg_data[30:0];
				REG_ABS_SCALE:  abs_scale_q  <= cfg_data;
				REG_BACKGROUND: background_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input unpack
	logic [7:0] raw;
	logic [2:0] rclass;
	logic       bad;
	logic [5:0] mask;
	side_t      side_in;
	logic [2:0] cls_in;
	logic       calc_in;
	logic [32:0] t0;

	// priority checks and offset removal
	always_comb begin
		raw           = s_axis_tdata[7:0];
		rclass        = s_axis_tuser[2:0];
		bad           = s_axis_tuser[3];
		mask          = s_axis_tuser[9:4];
		calc_in       = 1'b0;
		if (bad) begin
			cls_in = CLS_NULL;
		end else if (rclass != CLS_VALID) begin
			cls_in = (rclass > CLS_HIGH_REPR) ? CLS_NULL : rclass;
		end else if (raw >= sat_thresh_q) begin
			cls_in = CLS_HIGH_REPR;
		end else if (mask[0] || (s_axis_tdata[39:8] == '0)) begin
			cls_in = CLS_NULL;
		end else if (|mask[5:1]) begin
			cls_in = CLS_NULL;
		end else begin
			cls_in  = CLS_VALID;
			calc_in = 1'b1;
		end
		t0            = sat36(($signed({28'd0, raw}) <<< FRAC_BITS) - DOFS_C);
		side_in.cls   = cls_in;
		side_in.calc  = calc_in;
		side_in.ov    = t0[32];
		side_in.flat  = s_axis_tdata[39:8];
		side_in.oflat = s_axis_tdata[71:40];
		side_in.addv  = s_axis_tdata[103:72];
		side_in.dark  = s_axis_tdata[135:104];
		side_in.bias  = s_axis_tdata[167:136];
	end

	logic               v_s1;
	logic signed [31:0] t_s1;
	side_t              side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t0[31:0];
			side_s1 <= side_in;
		end
	end

	// gain division
	logic               d1_v, d1_ov;
	logic signed [31:0] d1_q;
	logic [SW-1:0]      d1_side;

	nprc_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_gain (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .a(t_s1), .b($signed({2'b00, gain_q})), .in_side(side_s1),
		.out_valid(d1_v), .q(d1_q), .q_ov(d1_ov), .out_side(d1_side)
	);

	// bias terms
	side_t       sd1;
	logic [32:0] t2;
	always_comb begin
		sd1    = side_t'(d1_side);
		t2     = sat36(36'(d1_q) - GB_C - 36'(sd1.bias)
			+ $signed({34'd0, ofs_mode_q}) * VM_C);
		sd1.ov = sd1.ov | d1_ov | t2[32];
	end

	logic               v_s2;
	logic signed [31:0] t_s2;
	side_t              side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t2[31:0];
			side_s2 <= sd1;
		end
	end

	// exposure division
	logic               d2_v, d2_ov;
	logic signed [31:0] d2_q;
	logic [SW-1:0]      d2_side;

	nprc_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_exp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .a(t_s2), .b($signed({2'b00, exposure_q})), .in_side(side_s2),
		.out_valid(d2_v), .q(d2_q), .q_ov(d2_ov), .out_side(d2_side)
	);

	// dark and background removal
	side_t       sd2;
	logic [32:0] t3a, t3b;
	always_comb begin
		sd2    = side_t'(d2_side);
		t3a    = sat36(36'(d2_q) - GD_C - 36'(sd2.dark));
		t3b    = sat36(36'($signed(t3a[31:0])) - 36'(background_q));
		sd2.ov = sd2.ov | d2_ov | t3a[32] | t3b[32];
	end

	logic               v_s3;
	logic signed [31:0] t_s3;
	side_t              side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3    <= t3b[31:0];
			side_s3 <= sd2;
		end
	end

	// flat field division
	logic               d3_v, d3_ov;
	logic signed [31:0] d3_q;
	logic [SW-1:0]      d3_side;

	nprc_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_flat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .a(t_s3), .b(33'(side_s3.flat)), .in_side(side_s3),
		.out_valid(d3_v), .q(d3_q), .q_ov(d3_ov), .out_side(d3_side)
	);

	side_t sd3;
	always_comb begin
		sd3    = side_t'(d3_side);
		sd3.ov = sd3.ov | d3_ov;
	end

	// orbit flat division
	logic               d4_v, d4_ov;
	logic signed [31:0] d4_q;
	logic [SW-1:0]      d4_side;

	nprc_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_oflat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d3_v), .a(d3_q), .b(33'(sd3.oflat)), .in_side(SW'(sd3)),
		.out_valid(d4_v), .q(d4_q), .q_ov(d4_ov), .out_side(d4_side)
	);

	// additive term
	side_t       sd4;
	logic [32:0] t5;
	always_comb begin
		sd4    = side_t'(d4_side);
		t5     = sat36(36'(d4_q) - 36'(sd4.addv));
		sd4.ov = sd4.ov | d4_ov | t5[32];
	end

	logic               v_s5;
	logic signed [31:0] t_s5;
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= d4_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5    <= t5[31:0];
			side_s5 <= sd4;
		end
	end

	// absolute scale
	logic               mu_v, mu_ov;
	logic signed [31:0] mu_p;
	side_t              mu_side;

	nprc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .a(t_s5), .b(abs_scale_q), .in_side(side_s5),
		.out_valid(mu_v), .p(mu_p), .p_ov(mu_ov), .out_side(mu_side)
	);

	// output register, non-calibrated kinds carry zero value and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= mu_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= mu_side.calc ? mu_p : 32'd0;
			m_axis_tuser <= {mu_side.calc & (mu_side.ov | mu_ov), mu_side.cls};
		end
	end

	ap_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] != CLS_VALID)
		|-> (m_axis_tdata == 32'd0) && !m_axis_tuser[3])
		else $error("non-calibrated result carries data");

	ap_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2:0] <= CLS_HIGH_REPR))
		else $error("result kind out of range");

	ap_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import nprc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam int LATENCY = 4 * (34 + FRAC_BITS) + 7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// raw pixel kind beyond those in the package
	localparam logic [2:0] KIND_HIGH_INSTR = 3'd4;

	typedef struct {
		logic [7:0]         raw;
		logic [2:0]         kind;
		logic signed [31:0] flat;
		logic signed [31:0] oflat;
		logic signed [31:0] addv;
		logic signed [31:0] dark;
		logic signed [31:0] bias;
		logic               bad;
		logic [5:0]         mask;
	} pixel_t;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        ov;
	} radiance_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata;
	logic [9:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic [3:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	// calibration settings mirrored from register writes
	logic [7:0]         sat_thresh;
	logic [30:0]        gain;
	logic [1:0]         ofs_mode;
	logic [30:0]        exposure;
	logic signed [31:0] abs_scale;
	logic signed [31:0] background;

	radiance_t expected_radiance[$];
	int  mismatches;
	int  pixels_sent;
	int  radiances_seen;
	int  idle_cycles;
	bit  sink_idle_on;
	bit  sink_hold;
	bit  timed_out;

	nir_pixel_radiometric_calibration_core #(.FRAC_BITS(FRAC_BITS)) dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// fixed point helpers
	function automatic longint clamp32(input longint v, inout bit ov);
		if (v > Q_MAX) begin
			ov = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			ov = 1'b1;
			return Q_MIN;
		end
		return v;
	endfunction

	function automatic longint fx_div(input longint a, input longint b, inout bit ov);
		if (b == 0) begin
			ov = 1'b1;
			return (a >= 0) ? Q_MAX : Q_MIN;
		end
		return clamp32((a * (64'sd1 <<< FRAC_BITS)) / b, ov);
	endfunction

	function automatic longint fx_round(input longint num, input longint den);
		return (num * (64'sd1 <<< FRAC_BITS) + den / 2) / den;
	endfunction

	// expected radiance of one pixel
	function automatic radiance_t calibrate_pixel(input pixel_t p);
		radiance_t r;
		bit ov;
		longint t;
		longint prod;
		longint mag;
		r.kind = CLS_NULL;
		r.value = '0;
		r.ov = 1'b0;
		ov = 1'b0;
		if (p.bad) begin
			r.kind = CLS_NULL;
		end else if (p.kind != CLS_VALID) begin
			r.kind = (p.kind > CLS_HIGH_REPR) ? CLS_NULL : p.kind;
		end else if (p.raw >= sat_thresh) begin
			r.kind = CLS_HIGH_REPR;
		end else if (p.mask[0] || p.flat == 0) begin
			r.kind = CLS_NULL;
		end else if (p.mask[5:1] != 0) begin
			r.kind = CLS_NULL;
		end else begin
			r.kind = CLS_VALID;
			t = clamp32((longint'(p.raw) <<< FRAC_BITS) - fx_round(830690, 100000), ov);
			t = fx_div(t, longint'(gain), ov);
			t = clamp32(t - fx_round(215547, 100000) - longint'(p.bias)
				+ longint'(ofs_mode) * fx_round(954194, 1000000), ov);
			t = fx_div(t, longint'(exposure), ov);
			t = clamp32(t - fx_round(730, 1000) - longint'(p.dark), ov);
			t = clamp32(t - longint'(background), ov);
			t = fx_div(t, longint'(p.flat), ov);
			t = fx_div(t, longint'(p.oflat), ov);
			t = clamp32(t - longint'(p.addv), ov);
			prod = t * longint'(abs_scale);
			mag = (prod < 0) ? -prod : prod;
			mag = mag >>> FRAC_BITS;
			t = clamp32((prod < 0) ? -mag : mag, ov);
			r.value = t[31:0];
			r.ov = ov;
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SAT_THRESH: sat_thresh = val[7:0];
			REG_GAIN:       gain = val[30:0];
			REG_OFS_MODE:   ofs_mode = val[1:0];
			REG_EXPOSURE:   exposure = val[30:0];
			REG_ABS_SCALE:  abs_scale = val;
			REG_BACKGROUND: background = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one pixel transaction; optional idle burst before it
	task automatic send_pixel(input pixel_t p, input bit allow_idle);
		int gap;
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.bias, p.dark, p.addv, p.oflat, p.flat, p.raw};
		s_axis_tuser <= {p.mask, p.bad, p.kind};
		do @(posedge clk); while (!s_axis_tready);
		expected_radiance = {expected_radiance, calibrate_pixel(p)};
		pixels_sent++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_radiance.size() != 0 && !timed_out) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return $urandom_range(0, 1) ? $urandom_range(1, 32'h0003_0000)
				: -$urandom_range(1, 32'h0003_0000);
			default: return $urandom;
		endcase
	endfunction

	// mostly calibratable pixels with random content, the rest noise
	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.raw = 8'($urandom);
		p.flat = rand_q();
		p.oflat = rand_q();
		p.addv = rand_q();
		p.dark = rand_q();
		p.bias = rand_q();
		if ($urandom_range(0, 3) != 0) begin
			p.kind = CLS_VALID;
			p.bad = 1'b0;
			p.mask = '0;
			if (p.flat == 0) p.flat = 32'h0001_0000;
		end else begin
			p.kind = 3'($urandom);
			p.bad = $urandom_range(0, 3) == 0;
			p.mask = 6'($urandom);
		end
		return p;
	endfunction

	function automatic pixel_t plain_pixel(input logic [7:0] raw);
		pixel_t p;
		p.raw = raw;
		p.kind = CLS_VALID;
		p.flat = 32'h0001_0000;
		p.oflat = 32'h0001_0000;
		p.addv = '0;
		p.dark = '0;
		p.bias = '0;
		p.bad = 1'b0;
		p.mask = '0;
		return p;
	endfunction

	task automatic test_directed();
		pixel_t p;
		p = plain_pixel(8'd0);
		send_pixel(p, 0);
		p = plain_pixel(8'd254);
		send_pixel(p, 0);
		// saturation at threshold
		p = plain_pixel(8'd255);
		send_pixel(p, 0);
		// bad pixel wins over everything
		p = plain_pixel(8'd10); p.bad = 1'b1; p.kind = KIND_HIGH_INSTR; p.mask = 6'h3F;
		send_pixel(p, 0);
		// raw kinds passed through, undefined ones null
		for (int k = 1; k < 8; k++) begin
			p = plain_pixel(8'd10); p.kind = k[2:0];
			send_pixel(p, 0);
		end
		// zero flat and flat flag
		p = plain_pixel(8'd10); p.flat = '0;
		send_pixel(p, 0);
		p = plain_pixel(8'd10); p.mask = 6'h01;
		send_pixel(p, 0);
		// each other special plane
		for (int b = 1; b < 6; b++) begin
			p = plain_pixel(8'd10); p.mask = 6'h01 << b;
			send_pixel(p, 0);
		end
		// divide by zero orbit flat, both signs
		p = plain_pixel(8'd100); p.oflat = '0;
		send_pixel(p, 0);
		p = plain_pixel(8'd0); p.oflat = '0;
		send_pixel(p, 0);
		// extreme planes force step saturation
		p = plain_pixel(8'd200); p.bias = 32'h8000_0000; p.dark = 32'h8000_0000;
		p.addv = 32'h8000_0000; p.flat = 32'h0000_0001; p.oflat = 32'hFFFF_FFFF;
		send_pixel(p, 0);
		p = plain_pixel(8'd1); p.bias = 32'h7FFF_FFFF; p.dark = 32'h7FFF_FFFF;
		p.addv = 32'h7FFF_FFFF; p.flat = 32'h8000_0000; p.oflat = 32'h7FFF_FFFF;
		send_pixel(p, 0);
		end_burst();
		drain();
	endtask

	task automatic test_settings(input logic [7:0] th, input logic [31:0] g,
			input logic [1:0] m, input logic [31:0] e, input logic [31:0] s,
			input logic [31:0] bg, input int count, input bit idle);
		write_reg(REG_SAT_THRESH, {24'd0, th});
		write_reg(REG_GAIN, g);
		write_reg(REG_OFS_MODE, {30'd0, m});
		write_reg(REG_EXPOSURE, e);
		write_reg(REG_ABS_SCALE, s);
		write_reg(REG_BACKGROUND, bg);
		sink_idle_on = idle;
		repeat (count) send_pixel(rand_pixel(), idle);
		end_burst();
		drain();
	endtask

	// receiver holds off long so the pipeline fills and backs up
	task automatic test_backpressure();
		sink_hold = 1'b1;
		fork
			begin
				repeat (LATENCY + 150) @(posedge clk);
				sink_hold = 1'b0;
			end
			begin
				repeat (LATENCY + 100) send_pixel(rand_pixel(), 0);
				end_burst();
			end
		join
		drain();
	endtask

	task automatic test_random_settings(input int phases);
		for (int i = 0; i < phases; i++) begin
			test_settings(8'($urandom), $urandom_range(1, 32'h0004_0000), 2'($urandom),
				$urandom_range(1, 32'h0004_0000), rand_q(), rand_q(), 60, 1);
		end
	endtask

	// output sink with random stall bursts
	always @(posedge clk) begin
		int stall;
		if (sink_hold) begin
			m_axis_tready <= 1'b0;
		end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall = $urandom_range(1, 13);
			repeat (stall - 1) @(posedge clk);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		radiance_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			radiances_seen++;
			if (expected_radiance.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected radiance transaction: kind %0d value %h",
						m_axis_tuser[2:0], m_axis_tdata);
			end else begin
				e = expected_radiance.pop_front();
				if (m_axis_tuser[2:0] !== e.kind || m_axis_tdata !== e.value
						|| m_axis_tuser[3] !== e.ov) begin
					mismatches++;
					if (mismatches <= 10)
						$display("radiance mismatch: exp kind %0d value %h ov %0d, got kind %0d value %h ov %0d",
							e.kind, e.value, e.ov, m_axis_tuser[2:0], m_axis_tdata,
							m_axis_tuser[3]);
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		pixels_sent = 0;
		radiances_seen = 0;
		idle_cycles = 0;
		sink_idle_on = 1'b0;
		sink_hold = 1'b0;
		timed_out = 1'b0;
		sat_thresh = 8'd255;
		gain = 31'd65536;
		ofs_mode = 2'd0;
		exposure = 31'd65536;
		abs_scale = 32'sd65536;
		background = 32'sd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// extremes of every register
		test_settings(8'd0, 32'd1, 2'd3, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 40, 1);
		test_settings(8'd255, 32'h7FFF_FFFF, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 40, 1);
		test_settings(8'd128, 32'h0001_0000, 2'd1, 32'h0000_8000, 32'h0001_0000, 32'd0,
			60, 1);
		test_backpressure();
		test_random_settings(10);
		// last stretch with no idling on either side
		test_settings(8'd250, 32'h0002_0000, 2'd2, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_4000, 200, 0);
		repeat (LATENCY + 20) @(posedge clk);

		$display("covered %0d pixels and %0d radiance transactions over many register settings",
			pixels_sent, radiances_seen);
		if (mismatches == 0 && expected_radiance.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d radiances missing", mismatches,
				expected_radiance.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/nprc_pkg.sv
hw/rtl/nprc_div.sv
hw/rtl/nprc_mul.sv
hw/rtl/nir_pixel_radiometric_calibration_core.sv
tb/sv/tb_top.sv
